// ----- rtl/banked_window_address_mapper_core_macros.svh -----
// Assertion macros shared by the address mapper RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BANKED_WINDOW_ADDRESS_MAPPER_CORE_MACROS_SVH
`define BANKED_WINDOW_ADDRESS_MAPPER_CORE_MACROS_SVH

// Checked on every clock edge outside reset
`define BWAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every clock edge, reset included
`define BWAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/bwam_pkg.sv -----
// Shared types, constants and window table for the address mapper.
// No dependencies.
`timescale 1ns / 1ps

package bwam_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned DevAddrW = 21;
  localparam int unsigned WinTypeW = 2;
  localparam int unsigned RouteW   = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  // Result route codes
  typedef enum logic [RouteW-1:0] {
    RouteSelReg     = 3'd0,
    RouteFlashRd    = 3'd1,
    RouteLcdRd      = 3'd2,
    RouteLcdWr      = 3'd3,
    RouteUnmapRd    = 3'd4,
    RouteOutOfRange = 3'd5,
    RouteFlashWr    = 3'd6
  } route_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgNormalType = 1'b0,
    CfgIrqType    = 1'b1
  } cfg_idx_e;

  // Window types; the unused code behaves as the prr bank
  typedef enum logic [WinTypeW-1:0] {
    WinIrqBank   = 2'd0,
    WinUpperBank = 2'd1,
    WinPrrBank   = 2'd2
  } win_type_e;

  localparam logic [WinTypeW-1:0] NormalTypeRst = WinPrrBank;
  localparam logic [WinTypeW-1:0] IrqTypeRst    = WinIrqBank;

  // Select register addresses
  localparam logic [AddrW-1:0] SelIrqLo   = 16'h0030;
  localparam logic [AddrW-1:0] SelIrqHi   = 16'h0031;
  localparam logic [AddrW-1:0] SelPrrLo   = 16'h0032;
  localparam logic [AddrW-1:0] SelPrrHi   = 16'h0033;
  localparam logic [AddrW-1:0] SelUpperLo = 16'h0034;
  localparam logic [AddrW-1:0] SelUpperHi = 16'h0035;

  // Window ranges
  localparam logic [AddrW-1:0] LowWinStart   = 16'h4000;
  localparam logic [AddrW-1:0] LowWinLast    = 16'h7fff;
  localparam logic [AddrW-1:0] UpperWinStart = 16'h8000;
  localparam logic [AddrW-1:0] UpperWinLast  = 16'hffff;

  // Device select codes in the high select byte
  localparam logic [1:0] UpperFlashSel = 2'd0;
  localparam logic [1:0] UpperLcdSel   = 2'd3;
  localparam logic [2:0] LowFlashSel   = 3'd0;
  localparam logic [2:0] LowLcdSel     = 3'd6;

  localparam logic [DataW-1:0] UnmappedByte = 8'hff;

  typedef struct packed {
    logic [AddrW-1:0] sel_lo;
    logic [AddrW-1:0] sel_hi;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] last;
    logic             upper;
  } win_desc_t;

  // Window descriptor lookup
  function automatic win_desc_t win_desc(input logic [WinTypeW-1:0] wtype);
    win_desc_t d;
    unique case (wtype)
      WinIrqBank:   d = '{SelIrqLo, SelIrqHi, LowWinStart, LowWinLast, 1'b0};
      WinUpperBank: d = '{SelUpperLo, SelUpperHi, UpperWinStart, UpperWinLast, 1'b1};
      default:      d = '{SelPrrLo, SelPrrHi, LowWinStart, LowWinLast, 1'b0};
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/bwam_in_if.sv -----
// Bus access channel (valid/ready plus access fields).
// Depends on bwam_pkg.
`timescale 1ns / 1ps

interface bwam_in_if;
  import bwam_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [AddrW-1:0]       bus_address;
  logic [DataW-1:0]       write_byte;
  logic                   in_interrupt;

  modport source (output valid, func, bus_address, write_byte, in_interrupt, input ready);
  modport sink   (input valid, func, bus_address, write_byte, in_interrupt, output ready);
endinterface

// ----- rtl/bwam_out_if.sv -----
// Routing result channel (valid/ready plus result fields).
// Depends on bwam_pkg.
`timescale 1ns / 1ps

interface bwam_out_if;
  import bwam_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RouteW-1:0]      route;
  logic [DataW-1:0]       read_data;
  logic [DevAddrW-1:0]    device_address;
  logic [DataW-1:0]       device_data;

  modport source (output valid, route, read_data, device_address, device_data, input ready);
  modport sink   (input valid, route, read_data, device_address, device_data, output ready);
endinterface

// ----- rtl/banked_window_address_mapper_core.sv -----
// Banked window address mapper: select byte registers and address routing.
// Depends on bwam_pkg, bwam_in_if, bwam_out_if and the assertion macro header.
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+--------------------------------------------
//  req_i   | in  | valid/ready        | func, bus_address, write_byte, in_interrupt
//  rsp_o   | out | valid/ready        | route, read_data, device_address, device_data
//  cfg     | in  | cfg_we_i, no ready | cfg_idx_i, cfg_data_i (window types)
//
// One beat per cycle while results are taken; each beat passes through the
// input register, where decode and select byte update happen, and then the
// result register. A stalled result holds the result register, and the input
// register then holds too. Reset clears the select bytes and loads the
// default window types; no clearing pass is needed.
`timescale 1ns / 1ps
`include "banked_window_address_mapper_core_macros.svh"

module banked_window_address_mapper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bwam_in_if.sink                       req_i,
  bwam_out_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bwam_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bwam_pkg::CfgDataW-1:0] cfg_data_i
);
  import bwam_pkg::*;

  // Configuration and select byte state
  logic [WinTypeW-1:0] nrm_type_q, irq_type_q;
  logic [DataW-1:0]    nrm_lo_q, nrm_hi_q, irq_lo_q, irq_hi_q;

  // Input register
  logic                s1_valid_q;
  logic                s1_func_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic [DataW-1:0]    s1_data_q;
  logic                s1_irq_q;

  // Result register
  logic                out_valid_q;
  route_e              route_q, route_d;
  logic [DataW-1:0]    rd_q, rd_d;
  logic [DevAddrW-1:0] da_q, da_d;
  logic [DataW-1:0]    dd_q, dd_d;

  logic                s1_adv;
  logic                in_fire;

  win_desc_t           nw, iw, win;
  logic                hit_nlo, hit_nhi, hit_ilo, hit_ihi, sel_hit;
  logic [DataW-1:0]    sel_byte;
  logic [DataW-1:0]    win_lo, win_hi;
  logic                in_range;
  logic [AddrW-1:0]    off;
  logic                is_flash, is_lcd;
  logic [DevAddrW-1:0] flash_addr, lcd_addr;

  // Handshake: the input register moves on whenever the result register frees up
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = req_i.valid && req_i.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_type_q <= NormalTypeRst;
      irq_type_q <= IrqTypeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgNormalType: nrm_type_q <= cfg_data_i;
        CfgIrqType:    irq_type_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= req_i.func;
      s1_addr_q <= req_i.bus_address;
      s1_data_q <= req_i.write_byte;
      s1_irq_q  <= req_i.in_interrupt;
    end
  end

  // Select register decode; the normal window wins a clash
  assign nw      = win_desc(nrm_type_q);
  assign iw      = win_desc(irq_type_q);
  assign hit_nlo = (s1_addr_q == nw.sel_lo);
  assign hit_nhi = !hit_nlo && (s1_addr_q == nw.sel_hi);
  assign hit_ilo = !hit_nlo && !hit_nhi && (s1_addr_q == iw.sel_lo);
  assign hit_ihi = !hit_nlo && !hit_nhi && !hit_ilo && (s1_addr_q == iw.sel_hi);
  assign sel_hit = hit_nlo || hit_nhi || hit_ilo || hit_ihi;

  always_comb begin
    priority if (hit_nlo) begin
      sel_byte = nrm_lo_q;
    end else if (hit_nhi) begin
      sel_byte = nrm_hi_q;
    end else if (hit_ilo) begin
      sel_byte = irq_lo_q;
    end else begin
      sel_byte = irq_hi_q;
    end
  end

  // Select byte writes take effect as the beat leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_lo_q <= '0;
      nrm_hi_q <= '0;
      irq_lo_q <= '0;
      irq_hi_q <= '0;
    end else if (s1_adv && s1_func_q) begin
      if (hit_nlo) nrm_lo_q <= s1_data_q;
      if (hit_nhi) nrm_hi_q <= s1_data_q;
      if (hit_ilo) irq_lo_q <= s1_data_q;
      if (hit_ihi) irq_hi_q <= s1_data_q;
    end
  end

  // Window translation
  assign win      = s1_irq_q ? iw : nw;
  assign win_lo   = s1_irq_q ? irq_lo_q : nrm_lo_q;
  assign win_hi   = s1_irq_q ? irq_hi_q : nrm_hi_q;
  assign in_range = (s1_addr_q >= win.start) && (s1_addr_q <= win.last);
  assign off      = s1_addr_q - win.start;

  always_comb begin
    if (win.upper) begin
      is_flash   = (win_hi[1:0] == UpperFlashSel);
      is_lcd     = (win_hi[1:0] == UpperLcdSel);
      // 32K pages: page number sits above the 15-bit offset
      flash_addr = {win_lo[5:0], off[14:0]};
      lcd_addr   = {6'd0, off[14:0]};
    end else begin
      is_flash   = (win_hi[2:0] == LowFlashSel);
      is_lcd     = (win_hi[2:0] == LowLcdSel);
      // 16K pages
      flash_addr = {win_lo[6:0], off[13:0]};
      lcd_addr   = {6'd0, win_lo[0], off[13:0]};
    end
  end

  // Route selection
  always_comb begin
    route_d = RouteSelReg;
    rd_d    = '0;
    da_d    = '0;
    dd_d    = '0;
    priority if (sel_hit) begin
      route_d = RouteSelReg;
      rd_d    = s1_func_q ? '0 : sel_byte;
    end else if (!in_range) begin
      route_d = RouteOutOfRange;
      rd_d    = UnmappedByte;
    end else if (s1_func_q) begin
      if (is_lcd) begin
        route_d = RouteLcdWr;
        da_d    = lcd_addr;
        dd_d    = s1_data_q;
      end else begin
        route_d = RouteFlashWr;
      end
    end else if (is_flash) begin
      route_d = RouteFlashRd;
      da_d    = flash_addr;
    end else if (is_lcd) begin
      route_d = RouteLcdRd;
      da_d    = lcd_addr;
    end else begin
      route_d = RouteUnmapRd;
      rd_d    = UnmappedByte;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      route_q <= route_d;
      rd_q    <= rd_d;
      da_q    <= da_d;
      dd_q    <= dd_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.route          = route_q;
  assign rsp_o.read_data      = rd_q;
  assign rsp_o.device_address = da_q;
  assign rsp_o.device_data    = dd_q;

  // Checks
  `BWAM_ASSERT(a_adv_fills_out, s1_adv |=> out_valid_q, "beat lost between stages")
  `BWAM_ASSERT(a_nlo_write, (s1_adv && s1_func_q && hit_nlo) |=> (nrm_lo_q == $past(s1_data_q)), "normal low select byte not stored")
  `BWAM_ASSERT(a_ff_routes, (out_valid_q && (route_q == RouteOutOfRange || route_q == RouteUnmapRd)) |-> (rd_q == UnmappedByte), "unmapped route without 0xff")
  `BWAM_ASSERT(a_dev_data, (out_valid_q && route_q != RouteLcdWr) |-> (dd_q == '0), "device data outside lcd write")
  `BWAM_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> req_i.ready, "input stalled with empty result register")

endmodule
